[rtl/core/blam_pkg.sv]
// Shared types and constants for the block average level meter.
// No dependencies; imported by every module of the block.
package blam_pkg;

    localparam int SAMPLE_W                = 24;
    localparam int SUM_W                   = 32;
    localparam int SAMPLE_BITS_MAX_DEFAULT = 24;

    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 152;

    localparam logic [7:0] BLOCK_SIZE_RST    = 8'd5;
    localparam logic [7:0] BAR_WIDTH_RST     = 8'd73;
    localparam logic [4:0] SAMPLE_BITS_RST   = 5'd16;
    localparam logic [3:0] CHANNEL_COUNT_RST = 4'd1;

    typedef enum logic [2:0] {
        CFG_BLOCK_SIZE    = 3'd0,
        CFG_BAR_WIDTH     = 3'd1,
        CFG_SAMPLE_BITS   = 3'd2,
        CFG_CHANNEL_COUNT = 3'd3,
        CFG_DISPLAY_OFF   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        RGN_NEG_CLIP = 3'd0,
        RGN_NEG_BAR  = 3'd1,
        RGN_ZERO     = 3'd2,
        RGN_POS_CLIP = 3'd3,
        RGN_POS_BAR  = 3'd4
    } region_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CHECK,
        ST_AVG,
        ST_SCALE,
        ST_BAR,
        ST_OUT
    } state_t;

    // Statistics state as seen by the sequencer. Signed values are kept as raw bits.
    typedef struct packed {
        logic [31:0]         frame;
        logic [7:0]          block_count;
        logic [SUM_W-1:0]    block_sum;
        logic                clip_hi;
        logic                clip_lo;
        logic [SAMPLE_W-1:0] run_max;
        logic [SAMPLE_W-1:0] run_min;
        logic [31:0]         clip_cnt;
    } stats_t;

    typedef struct packed {
        logic upd;
        logic clr;
    } stats_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/core/blam_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on blam_pkg for the status struct.
module blam_div
    import blam_pkg::*;
#(
    parameter int DIV_W = 32,
    parameter int DVS_W = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output div_stat_t        stat
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] rem_sub;
    logic           ge;

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/core/blam_stats.sv]
// Per-sample statistics: clip detection and count, peaks, block sum and count,
// channel and frame counters. Depends on blam_pkg.
module blam_stats
    import blam_pkg::*;
#(
    parameter int CW = 25
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  stats_ctl_t                 ctl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [CW-1:0]       full_val,
    input  logic signed [CW-1:0]       lo_val,
    input  logic [3:0]                 chans,
    output stats_t                     st
);

    logic [31:0]                frame_reg, frame_next;
    logic [2:0]                 chan_reg, chan_next;
    logic [7:0]                 count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       hi_reg, hi_next;
    logic                       lo_reg, lo_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic [31:0]                clip_reg, clip_next;

    logic signed [CW-1:0] smp_ext;
    logic                 is_hi;
    logic                 is_lo;
    logic [3:0]           chan_inc;

    assign smp_ext  = CW'(sample);
    assign is_hi    = smp_ext >= full_val;
    assign is_lo    = smp_ext <= lo_val;
    assign chan_inc = {1'b0, chan_reg} + 4'd1;

    always_comb begin
        frame_next = frame_reg;
        chan_next  = chan_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        clip_next  = clip_reg;
        if (ctl.upd) begin
            if (is_hi) hi_next = 1'b1;
            if (is_lo) lo_next = 1'b1;
            // The two limits never overlap, so at most one clip per sample.
            if ((is_hi || is_lo) && clip_reg != 32'hFFFF_FFFF) begin
                clip_next = clip_reg + 32'd1;
            end
            if (sample > max_reg) max_next = sample;
            if (sample < min_reg) min_next = sample;
            sum_next   = sum_reg + SUM_W'(sample);
            count_next = count_reg + 8'd1;
            if (chan_inc >= chans) begin
                chan_next  = 3'd0;
                frame_next = frame_reg + 32'd1;
            end else begin
                chan_next = chan_inc[2:0];
            end
        end else if (ctl.clr) begin
            sum_next   = '0;
            count_next = 8'd0;
            hi_next    = 1'b0;
            lo_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
            chan_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            hi_reg    <= 1'b0;
            lo_reg    <= 1'b0;
            max_reg   <= '0;
            min_reg   <= '0;
            clip_reg  <= '0;
        end else begin
            frame_reg <= frame_next;
            chan_reg  <= chan_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
            clip_reg  <= clip_next;
        end
    end

    assign st.frame       = frame_reg;
    assign st.block_count = count_reg;
    assign st.block_sum   = sum_reg;
    assign st.clip_hi     = hi_reg;
    assign st.clip_lo     = lo_reg;
    assign st.run_max     = max_reg;
    assign st.run_min     = min_reg;
    assign st.clip_cnt    = clip_reg;

endmodule

[rtl/core/block_average_level_meter_unit.sv]
// Top level of the block average level meter: configuration registers,
// sequencer, output register. Depends on blam_pkg, blam_stats and blam_div.
//
// Every input beat yields exactly one output beat. A sample that does not end
// a block (or ends one while the display is off) goes from the update state
// through the check state to the out state. A sample that ends a block also
// passes the average, scale and bar states: the one shared divider runs
// once for the block average and once more for the bar length, one quotient
// bit per cycle. A clipped block skips the average pass, and the zero and
// clip regions skip the bar pass. s_tready is high only while the sequencer
// is idle; the output register lets the next beat be taken while a result
// still waits on m_tready.
module block_average_level_meter_unit
    import blam_pkg::*;
#(
    parameter int MAX_SAMPLE_BITS = SAMPLE_BITS_MAX_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_addr,
    input  logic [7:0]             cfg_wdata,
    // Input stream. tdata: sample[23:0].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // Output stream. tuser: block_ready.
    // tdata: frame_index[31:0], shown_value[56:32], bar_region[59:57],
    // bar_length[66:60], peak_high[89:67], peak_low[113:90],
    // clip_total[145:114], zero pad[151:146].
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   m_tuser,
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    localparam int CW    = (MAX_SAMPLE_BITS + 1 > 25) ? MAX_SAMPLE_BITS + 1 : 25;
    localparam int DIV_W = (CW + 6 > SUM_W) ? CW + 6 : SUM_W;
    localparam int DVS_W = MAX_SAMPLE_BITS;
    localparam int BW0   = $clog2(MAX_SAMPLE_BITS + 1);
    localparam int BW    = (BW0 > 5) ? BW0 : 5;

    // Configuration registers.
    logic [7:0] block_size_reg;
    logic [7:0] bar_width_reg;
    logic [4:0] sample_bits_reg;
    logic [3:0] channel_count_reg;
    logic       display_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg    <= BLOCK_SIZE_RST;
            bar_width_reg     <= BAR_WIDTH_RST;
            sample_bits_reg   <= SAMPLE_BITS_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
            display_off_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BLOCK_SIZE:    block_size_reg    <= cfg_wdata;
                CFG_BAR_WIDTH:     bar_width_reg     <= cfg_wdata;
                CFG_SAMPLE_BITS:   sample_bits_reg   <= cfg_wdata[4:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[3:0];
                CFG_DISPLAY_OFF:   display_off_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Derived settings.
    logic [BW-1:0]        sb_ext;
    logic [BW-1:0]        bits_eff;
    logic signed [CW-1:0] full_val;
    logic signed [CW-1:0] lo_val;
    logic [CW-1:0]        full_m1;
    logic [7:0]           size_eff;
    logic [3:0]           chans_eff;
    logic [6:0]           half;
    logic [6:0]           hneg;

    assign sb_ext = BW'(sample_bits_reg);

    always_comb begin
        if (sb_ext < BW'(2)) begin
            bits_eff = BW'(2);
        end else if (sb_ext > BW'(MAX_SAMPLE_BITS)) begin
            bits_eff = BW'(MAX_SAMPLE_BITS);
        end else begin
            bits_eff = sb_ext;
        end
    end

    assign full_val  = CW'(1) << (bits_eff - BW'(1));
    assign lo_val    = CW'(1) - full_val;
    assign full_m1   = full_val - CW'(1);
    assign size_eff  = (block_size_reg == 8'd0) ? 8'd1 : block_size_reg;
    assign chans_eff = (channel_count_reg == 4'd0) ? 4'd1 :
                       (channel_count_reg > 4'd8) ? 4'd8 : channel_count_reg;
    assign half      = bar_width_reg[7:1];
    assign hneg      = (half == 7'd0) ? 7'd0 : half - 7'd1;

    // Statistics unit.
    stats_ctl_t st_ctl;
    stats_t     st;
    logic signed [SAMPLE_W-1:0] sample_reg;

    blam_stats #(
        .CW (CW)
    ) u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (st_ctl),
        .sample   (sample_reg),
        .full_val (full_val),
        .lo_val   (lo_val),
        .chans    (chans_eff),
        .st       (st)
    );

    // Shared divider.
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quo;
    div_stat_t        div_stat;

    blam_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Sequencer state and working registers.
    state_t               state_reg, state_next;
    logic [31:0]          frame_reg, frame_next;
    logic                 ready_reg, ready_next;
    logic signed [CW-1:0] amp_reg, amp_next;
    region_t              region_reg, region_next;
    logic [6:0]           len_reg, len_next;
    logic                 neg_reg, neg_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_tuser_reg, m_tuser_next;
    logic [TDATA_OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic [SAMPLE_W-1:0]  sample_next;

    logic                 block_end;
    logic [SUM_W-1:0]     sum_abs;
    logic [CW-1:0]        avg_mag;
    region_t              region_now;
    logic [6:0]           scale;
    logic [CW-2:0]        mag;
    logic [CW+5:0]        prod;
    logic                 out_load;

    assign block_end = st.block_count >= size_eff;
    assign sum_abs   = st.block_sum[SUM_W-1] ? SUM_W'(0) - st.block_sum : st.block_sum;
    assign avg_mag   = div_quo[CW-1:0];

    always_comb begin
        if (amp_reg <= lo_val) begin
            region_now = RGN_NEG_CLIP;
        end else if (amp_reg < 0) begin
            region_now = RGN_NEG_BAR;
        end else if (amp_reg == 0) begin
            region_now = RGN_ZERO;
        end else if (amp_reg >= full_val) begin
            region_now = RGN_POS_CLIP;
        end else begin
            region_now = RGN_POS_BAR;
        end
    end

    // Negative bars scale by (half - 1) over (F - 1), positive ones by half over F.
    assign scale = (region_now == RGN_NEG_BAR) ? hneg : half;
    assign mag   = (region_now == RGN_NEG_BAR) ? (CW - 1)'(CW'(0) - amp_reg)
                                               : amp_reg[CW-2:0];
    assign prod  = scale * mag;

    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        frame_next    = frame_reg;
        ready_next    = ready_reg;
        amp_next      = amp_reg;
        region_next   = region_reg;
        len_next      = len_reg;
        neg_next      = neg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        st_ctl        = '0;
        div_start     = 1'b0;
        div_dividend  = DIV_W'(sum_abs);
        div_divisor   = DVS_W'(size_eff);
        s_tready      = 1'b0;
        out_load      = 1'b0;

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                st_ctl.upd = 1'b1;
                frame_next = st.frame;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                ready_next  = 1'b0;
                amp_next    = '0;
                region_next = RGN_NEG_CLIP;
                len_next    = 7'd0;
                neg_next    = st.block_sum[SUM_W-1];
                state_next  = ST_OUT;
                if (block_end) begin
                    st_ctl.clr = 1'b1;
                    if (!display_off_reg) begin
                        ready_next = 1'b1;
                        if (st.clip_hi) begin
                            amp_next   = full_val;
                            state_next = ST_SCALE;
                        end else if (st.clip_lo) begin
                            amp_next   = lo_val;
                            state_next = ST_SCALE;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_AVG;
                        end
                    end
                end
            end
            ST_AVG: begin
                if (div_stat.done) begin
                    amp_next   = neg_reg ? CW'(0) - avg_mag : avg_mag;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                region_next  = region_now;
                len_next     = 7'd0;
                div_dividend = DIV_W'(prod);
                div_divisor  = (region_now == RGN_NEG_BAR) ? full_m1[DVS_W-1:0]
                                                           : full_val[DVS_W-1:0];
                if (region_now == RGN_NEG_BAR || region_now == RGN_POS_BAR) begin
                    div_start  = 1'b1;
                    state_next = ST_BAR;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_BAR: begin
                if (div_stat.done) begin
                    len_next   = div_quo[6:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ready_reg;
                    m_tdata_next  = {6'd0, st.clip_cnt, st.run_min, st.run_max[22:0],
                                     len_reg, region_reg, amp_reg[24:0], frame_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sample_reg  <= sample_next;
        frame_reg   <= frame_next;
        ready_reg   <= ready_next;
        amp_reg     <= amp_next;
        region_reg  <= region_next;
        len_reg     <= len_next;
        neg_reg     <= neg_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // The divider is never restarted while an earlier division is running.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A new result never overwrites a beat that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output beat overwritten");

    // A completed block leaves the accumulator empty.
    a_block_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && block_end) |=> (st.block_count == 8'd0))
        else $error("block count not cleared at block end");

    // Clip and zero regions carry no bar marks.
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (region_reg == RGN_NEG_CLIP || region_reg == RGN_ZERO
            || region_reg == RGN_POS_CLIP)) |-> (len_reg == 7'd0))
        else $error("bar length set outside a bar region");

    // Beats without a finished block show nothing.
    a_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !ready_reg) |-> (amp_reg == 0 && len_reg == 7'd0))
        else $error("display fields set without a shown block");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for block_average_level_meter_unit: streams samples and
// register writes, predicts every output beat and compares it field by field.
// Depends on blam_pkg and the RTL of the block.
module tb_top;
    import blam_pkg::*;

    localparam int MAX_BITS    = SAMPLE_BITS_MAX_DEFAULT;
    localparam int SETTLE      = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 1000000;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 60;
    // An index that selects no register; a write to it must change nothing.
    localparam logic [2:0] CFG_NO_REG = 3'd6;

    // Blocks of three: both clips (high wins), low clip, positive bar,
    // negative bar with truncation toward zero, zero, 24-bit extremes, small negative.
    localparam logic signed [23:0] DIRECTED [21] = '{
        32768, -32767, 5,
        -32767, -4, -4,
        1000, 2000, 3000,
        -1000, -1, -2,
        0, 1, -1,
        8388607, -8388608, 32767,
        -7, -7, 0
    };

    typedef enum logic [1:0] {IT_SAMPLE, IT_CFG, IT_DRAIN, IT_HOLD} feed_kind_t;

    typedef struct {
        feed_kind_t  kind;
        logic [23:0] sample;
        logic [2:0]  addr;
        logic [7:0]  wdata;
        int          gap;
    } feed_t;

    typedef struct packed {
        logic        ready;
        logic [31:0] frame;
        logic [24:0] shown;
        logic [2:0]  region;
        logic [6:0]  len;
        logic [22:0] pk_hi;
        logic [23:0] pk_lo;
        logic [31:0] clips;
    } reading_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [2:0]             cfg_addr  = '0;
    logic [7:0]             cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   m_tuser;
    logic [TDATA_OUT_W-1:0] m_tdata;

    block_average_level_meter_unit dut (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tuser, .m_tdata
    );

    always #10 aclk = ~aclk;

    // Register copies and meter state mirrored by the predictor.
    logic [7:0]  p_block_size  = BLOCK_SIZE_RST;
    logic [7:0]  p_bar_width   = BAR_WIDTH_RST;
    logic [4:0]  p_sample_bits = SAMPLE_BITS_RST;
    logic [3:0]  p_channels    = CHANNEL_COUNT_RST;
    logic        p_display_off = 1'b0;
    int unsigned frame_cnt = 0;
    int unsigned chan_cnt  = 0;
    int unsigned blk_cnt   = 0;
    int unsigned clip_cnt  = 0;
    longint      blk_sum   = 0;
    longint      run_max   = 0;
    longint      run_min   = 0;
    bit          clip_hi   = 1'b0;
    bit          clip_lo   = 1'b0;

    feed_t       feed_q[$];
    reading_t    readings_due[$];
    int unsigned n_predicted = 0;
    int unsigned n_checked   = 0;
    int          mismatches  = 0;
    int          feed_idle   = 0;
    int          drain_wait  = SETTLE;
    int          gen_bits    = 16;
    logic        hold_start  = 1'b0;
    int          hold_left   = 0;
    int          rx_wait     = 0;
    int unsigned cycle_cnt   = 0;

    function automatic reading_t next_reading(logic [23:0] raw);
        longint      v, full, lo, avg, amp, half, hneg;
        int unsigned bits, chans, size;
        reading_t    r;
        v = longint'($signed(raw));
        bits = p_sample_bits;
        if (bits < 2) bits = 2;
        if (bits > MAX_BITS) bits = MAX_BITS;
        full = longint'(1) << (bits - 1);
        lo = 1 - full;
        if (v >= full) begin
            clip_hi = 1'b1;
            if (clip_cnt != 32'hFFFF_FFFF) clip_cnt++;
        end
        if (v <= lo) begin
            clip_lo = 1'b1;
            if (clip_cnt != 32'hFFFF_FFFF) clip_cnt++;
        end
        if (v > run_max) run_max = v;
        if (v < run_min) run_min = v;
        blk_sum += v;
        blk_cnt++;

        r = '0;
        r.frame = frame_cnt;
        chans = (p_channels == 0) ? 1 : (p_channels > 8) ? 8 : p_channels;
        chan_cnt++;
        if (chan_cnt >= chans) begin
            chan_cnt = 0;
            frame_cnt++;
        end

        // The block ends once the count reaches or passes the current size.
        size = (p_block_size == 0) ? 1 : p_block_size;
        if (blk_cnt >= size) begin
            avg = blk_sum / longint'(size);
            amp = clip_hi ? full : (clip_lo ? lo : avg);
            if (!p_display_off) begin
                half = p_bar_width / 2;
                hneg = (half > 0) ? half - 1 : 0;
                r.ready = 1'b1;
                r.shown = amp[24:0];
                if (amp <= lo) begin
                    r.region = RGN_NEG_CLIP;
                end else if (amp < 0) begin
                    r.region = RGN_NEG_BAR;
                    r.len = 7'((hneg * -amp) / (full - 1));
                end else if (amp == 0) begin
                    r.region = RGN_ZERO;
                end else if (amp >= full) begin
                    r.region = RGN_POS_CLIP;
                end else begin
                    r.region = RGN_POS_BAR;
                    r.len = 7'((half * amp) / full);
                end
            end
            blk_sum = 0;
            blk_cnt = 0;
            clip_hi = 1'b0;
            clip_lo = 1'b0;
        end
        r.pk_hi = run_max[22:0];
        r.pk_lo = run_min[23:0];
        r.clips = clip_cnt;
        return r;
    endfunction

    function automatic void set_register(logic [2:0] idx, logic [7:0] d);
        case (idx)
            CFG_BLOCK_SIZE:    p_block_size  = d;
            CFG_BAR_WIDTH:     p_bar_width   = d;
            CFG_SAMPLE_BITS:   p_sample_bits = d[4:0];
            CFG_CHANNEL_COUNT: p_channels    = d[3:0];
            CFG_DISPLAY_OFF:   p_display_off = d[0];
            default: ;
        endcase
    endfunction

    function automatic void add_feed(feed_kind_t k, logic [23:0] s, logic [2:0] a,
                                     logic [7:0] d, int gap);
        feed_t f;
        f.kind = k;
        f.sample = s;
        f.addr = a;
        f.wdata = d;
        f.gap = gap;
        feed_q.push_back(f);
        // Track the sample width so that random samples aim at the live clip limits.
        if (k == IT_CFG && a == CFG_SAMPLE_BITS)
            gen_bits = (d[4:0] < 2) ? 2 : (d[4:0] > MAX_BITS) ? MAX_BITS : d[4:0];
    endfunction

    function automatic logic [23:0] draw_sample();
        longint full, v;
        full = longint'(1) << (gen_bits - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = longint'($urandom_range(0, 2 * full)) - full;
            4, 5:       v = ($urandom_range(0, 1) ? full : 1 - full)
                            + longint'($urandom_range(0, 2)) - 1;
            6, 7:       v = $urandom();
            8:          v = longint'($urandom_range(0, 6)) - 3;
            default:    v = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
        endcase
        return v[23:0];
    endfunction

    function automatic void drop_head();
        feed_q.delete(0);
        feed_idle = (feed_q.size() != 0) ? feed_q[0].gap : 0;
    endfunction

    function automatic string fmt_reading(reading_t r);
        return $sformatf("rdy=%0d frame=%0d shown=%0d region=%0d len=%0d peak=%0d/%0d clips=%0d",
                         r.ready, r.frame, $signed(r.shown), r.region, r.len,
                         r.pk_hi, $signed(r.pk_lo), r.clips);
    endfunction

    task automatic report_bad(string what, reading_t want, reading_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at result %0d", what, n_checked);
            $display("  expected %s", fmt_reading(want));
            $display("  actual   %s", fmt_reading(got));
        end
    endtask

    // Sender: works through the pending queue, one entry at a time.
    always @(posedge aclk) begin : feeder
        logic        nv, nwe, nhold;
        logic [2:0]  naddr;
        logic [7:0]  nwdata;
        logic [23:0] ndata;
        if (!aresetn) begin
            feed_idle = 0;
            drain_wait = SETTLE;
            s_tvalid   <= 1'b0;
            cfg_we     <= 1'b0;
            hold_start <= 1'b0;
        end else begin
            nv = s_tvalid;
            ndata = s_tdata;
            nwe = 1'b0;
            naddr = cfg_addr;
            nwdata = cfg_wdata;
            nhold = 1'b0;
            if (s_tvalid && s_tready) begin
                readings_due.push_back(next_reading(s_tdata));
                n_predicted <= n_predicted + 1;
                nv = 1'b0;
                drop_head();
            end
            if (!nv && feed_q.size() != 0) begin
                if (feed_idle != 0) begin
                    feed_idle--;
                end else begin
                    case (feed_q[0].kind)
                        IT_SAMPLE: begin
                            nv = 1'b1;
                            ndata = feed_q[0].sample;
                        end
                        IT_CFG: begin
                            nwe = 1'b1;
                            naddr = feed_q[0].addr;
                            nwdata = feed_q[0].wdata;
                            set_register(naddr, nwdata);
                            drop_head();
                        end
                        IT_DRAIN: begin
                            // Both counters are updated nonblocking, so they are read
                            // here as they stood before this edge.
                            if (n_predicted != n_checked) begin
                                drain_wait = SETTLE;
                            end else if (drain_wait != 0) begin
                                drain_wait--;
                            end else begin
                                drain_wait = SETTLE;
                                drop_head();
                            end
                        end
                        IT_HOLD: begin
                            nhold = 1'b1;
                            drop_head();
                        end
                        default: drop_head();
                    endcase
                end
            end
            s_tvalid   <= nv;
            s_tdata    <= ndata;
            cfg_we     <= nwe;
            cfg_addr   <= naddr;
            cfg_wdata  <= nwdata;
            hold_start <= nhold;
        end
    end

    // Long receiver stall, counted apart from the per-beat stalls.
    always @(posedge aclk) begin
        if (hold_start) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // Receiver: checks every accepted beat and draws a stall before the next one.
    always @(posedge aclk) begin : receiver
        reading_t got;
        reading_t want;
        int       w;
        w = 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[31:0], m_tdata[56:32], m_tdata[59:57],
                       m_tdata[66:60], m_tdata[89:67], m_tdata[113:90], m_tdata[145:114]};
                if (readings_due.size() == 0) begin
                    report_bad("Unexpected output beat", '0, got);
                end else begin
                    want = readings_due.pop_front();
                    n_checked <= n_checked + 1;
                    if (got.ready !== want.ready || got.frame !== want.frame ||
                        got.shown !== want.shown || got.region !== want.region ||
                        got.len !== want.len || got.pk_hi !== want.pk_hi ||
                        got.pk_lo !== want.pk_lo || got.clips !== want.clips)
                        report_bad("Mismatch", want, got);
                end
                // One stretch in four takes every beat without stalling.
                w = (((n_checked >> 6) % 4) == 3) ? 0 : $urandom_range(0, 19);
            end
            if (hold_start || hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                rx_wait  <= w;
                m_tready <= (w == 0);
            end else if (rx_wait != 0) begin
                rx_wait  <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] bsz, bw, sb, cc, doff;
        bit         calm, held;
        add_feed(IT_DRAIN, '0, '0, '0, 0);
        add_feed(IT_CFG, '0, CFG_BLOCK_SIZE, 8'd3, 0);
        foreach (DIRECTED[i])
            add_feed(IT_SAMPLE, DIRECTED[i], '0, '0, $urandom_range(0, 19));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    bsz = 8'd1; bw = 8'd4; sb = 8'd2; cc = 8'd1; doff = 8'd0;
                end
                1: begin
                    bsz = 8'd255; bw = 8'd254; sb = 8'd24; cc = 8'd8; doff = 8'd0;
                end
                2: begin
                    // Zero size and channel count, a too-narrow bar, width below two.
                    bsz = 8'd0; bw = 8'd1; sb = 8'hE0; cc = 8'h00; doff = 8'hFF;
                end
                3: begin
                    // Upper bits of the narrow registers must be dropped.
                    bsz = 8'd2; bw = 8'd0; sb = 8'hFF; cc = 8'hFC; doff = 8'hFE;
                end
                default: begin
                    bsz = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(1, 12));
                    bw = 8'($urandom_range(0, 255));
                    sb = {3'($urandom), ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                                   : 5'($urandom_range(2, 24))};
                    cc = {4'($urandom), 4'($urandom_range(0, 15))};
                    doff = {7'($urandom), 1'($urandom_range(0, 5) == 0)};
                end
            endcase
            add_feed(IT_DRAIN, '0, '0, '0, 0);
            add_feed(IT_CFG, '0, CFG_BLOCK_SIZE, bsz, 0);
            add_feed(IT_CFG, '0, CFG_BAR_WIDTH, bw, 0);
            add_feed(IT_CFG, '0, CFG_SAMPLE_BITS, sb, 0);
            add_feed(IT_CFG, '0, CFG_CHANNEL_COUNT, cc, 0);
            add_feed(IT_CFG, '0, CFG_DISPLAY_OFF, doff, 0);
            if (p == 2 || $urandom_range(0, 3) == 0)
                add_feed(IT_CFG, '0, CFG_NO_REG, 8'($urandom), 0);

            calm = (p % 4 == 1);
            held = (p == 4 || p == 11);
            // The receiver stops for a long stretch while samples keep coming.
            if (held) add_feed(IT_HOLD, '0, '0, '0, 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                add_feed(IT_SAMPLE, draw_sample(), '0, '0,
                         (calm || (held && i < 30)) ? 0 : $urandom_range(0, 19));
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (feed_q.size() != 0 || n_checked != n_predicted) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
